// File: rtl/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// tlbpt_pkg
// shared constants and types for the tlb page table translator
// ----------------------------------------------------------------------------
package tlbpt_pkg;
  localparam int TLB_ENTRIES_DEF     = 8;
  localparam int PROCESSES_DEF       = 4;
  localparam int MAX_PAGE_BITS_DEF   = 8;
  localparam int MAX_FRAME_BITS_DEF  = 8;
  localparam int MAX_OFFSET_BITS_DEF = 8;

  localparam int OP_W   = 2;
  localparam int PID_W  = 2;
  localparam int VA_W   = 16;
  localparam int PN_W   = 8;
  localparam int FN_W   = 8;
  localparam int ST_W   = 2;
  localparam int EIDX_W = 3;
  localparam int STAMP_W = 32;

  localparam logic [OP_W-1:0] OP_XLATE = 2'd0;
  localparam logic [OP_W-1:0] OP_MAP   = 2'd1;
  localparam logic [OP_W-1:0] OP_UNMAP = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_FILL  = 2'd1;
  localparam logic [ST_W-1:0] ST_FAULT = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  localparam logic [1:0] CFG_OFFSET = 2'd0;
  localparam logic [1:0] CFG_VPN    = 2'd1;
  localparam logic [1:0] CFG_LRU    = 2'd2;

  // command broadcast to every cell
  typedef struct packed {
    logic                 write;   // install at wr_idx
    logic                 clear;   // invalidate wr_idx
    logic                 touch;   // restamp wr_idx only
    logic [5:0]           wr_idx;
    logic [PN_W-1:0]      page;
    logic [FN_W-1:0]      frame;
    logic [PID_W-1:0]     owner;
    logic [STAMP_W-1:0]   stamp;
  } cell_cmd_t;
endpackage

// File: rtl/tlbpt_cell.sv
// ----------------------------------------------------------------------------
// tlbpt_cell
// one tlb entry; folds its match and victim candidate into the chain
// ----------------------------------------------------------------------------
module tlbpt_cell #(
  parameter int IDX_W = 3
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [IDX_W-1:0]           my_idx,
  input  logic [tlbpt_pkg::PN_W-1:0]  key_page,
  input  logic [tlbpt_pkg::PID_W-1:0] key_pid,
  input  tlbpt_pkg::cell_cmd_t        cmd,
  // chain in
  input  logic                       hit_i,
  input  logic [IDX_W-1:0]           hit_idx_i,
  input  logic [tlbpt_pkg::FN_W-1:0]  hit_frame_i,
  input  logic                       free_i,
  input  logic [IDX_W-1:0]           free_idx_i,
  input  logic [IDX_W-1:0]           old_idx_i,
  input  logic [tlbpt_pkg::STAMP_W-1:0] old_stamp_i,
  // chain out
  output logic                       hit_o,
  output logic [IDX_W-1:0]           hit_idx_o,
  output logic [tlbpt_pkg::FN_W-1:0]  hit_frame_o,
  output logic                       free_o,
  output logic [IDX_W-1:0]           free_idx_o,
  output logic [IDX_W-1:0]           old_idx_o,
  output logic [tlbpt_pkg::STAMP_W-1:0] old_stamp_o
);
  import tlbpt_pkg::*;

  logic               valid_r;
  logic [PN_W-1:0]    page_r;
  logic [FN_W-1:0]    frame_r;
  logic [PID_W-1:0]   owner_r;
  logic [STAMP_W-1:0] stamp_r;
  logic               me;
  logic               match;

  assign me    = (cmd.wr_idx[IDX_W-1:0] == my_idx);
  assign match = valid_r && page_r == key_page && owner_r == key_pid;

  // earlier cells win on match and free; strict less keeps lowest index on ties
  assign hit_o       = hit_i | match;
  assign hit_idx_o   = hit_i ? hit_idx_i : my_idx;
  assign hit_frame_o = hit_i ? hit_frame_i : frame_r;
  assign free_o      = free_i | !valid_r;
  assign free_idx_o  = free_i ? free_idx_i : my_idx;
  assign old_idx_o   = (stamp_r < old_stamp_i) ? my_idx : old_idx_i;
  assign old_stamp_o = (stamp_r < old_stamp_i) ? stamp_r : old_stamp_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      page_r  <= '0;
      frame_r <= '0;
      owner_r <= '0;
      stamp_r <= '0;
    end else if (me) begin
      if (cmd.write) begin
        valid_r <= 1'b1;
        page_r  <= cmd.page;
        frame_r <= cmd.frame;
        owner_r <= cmd.owner;
        stamp_r <= cmd.stamp;
      end else if (cmd.clear) begin
        valid_r <= 1'b0;
        page_r  <= '0;
        frame_r <= '0;
        owner_r <= '0;
      end else if (cmd.touch) begin
        stamp_r <= cmd.stamp;
      end
    end
  end
endmodule

// File: rtl/tlbpt_chain.sv
// ----------------------------------------------------------------------------
// tlbpt_chain
// row of tlb cells with the search chain registered at its end
// ----------------------------------------------------------------------------
module tlbpt_chain #(
  parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
  parameter int IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [tlbpt_pkg::PN_W-1:0]   key_page,
  input  logic [tlbpt_pkg::PID_W-1:0]  key_pid,
  input  tlbpt_pkg::cell_cmd_t         cmd,
  output logic                        hit_r,
  output logic [IDX_W-1:0]            hit_idx_r,
  output logic [tlbpt_pkg::FN_W-1:0]   hit_frame_r,
  output logic [IDX_W-1:0]            victim_r
);
  import tlbpt_pkg::*;

  logic               hit   [TLB_ENTRIES+1];
  logic [IDX_W-1:0]   hidx  [TLB_ENTRIES+1];
  logic [FN_W-1:0]    hfr   [TLB_ENTRIES+1];
  logic               free  [TLB_ENTRIES+1];
  logic [IDX_W-1:0]   fidx  [TLB_ENTRIES+1];
  logic [IDX_W-1:0]   oidx  [TLB_ENTRIES+1];
  logic [STAMP_W-1:0] ost   [TLB_ENTRIES+1];

  assign hit[0]  = 1'b0;
  assign hidx[0] = '0;
  assign hfr[0]  = '0;
  assign free[0] = 1'b0;
  assign fidx[0] = '0;
  assign oidx[0] = '0;
  assign ost[0]  = '1;

  for (genvar g = 0; g < TLB_ENTRIES; g++) begin : g_cell
    tlbpt_cell #(.IDX_W(IDX_W)) u_cell (
      .clk(clk), .rst_n(rst_n), .my_idx(IDX_W'(g)),
      .key_page(key_page), .key_pid(key_pid), .cmd(cmd),
      .hit_i(hit[g]), .hit_idx_i(hidx[g]), .hit_frame_i(hfr[g]),
      .free_i(free[g]), .free_idx_i(fidx[g]),
      .old_idx_i(oidx[g]), .old_stamp_i(ost[g]),
      .hit_o(hit[g+1]), .hit_idx_o(hidx[g+1]), .hit_frame_o(hfr[g+1]),
      .free_o(free[g+1]), .free_idx_o(fidx[g+1]),
      .old_idx_o(oidx[g+1]), .old_stamp_o(ost[g+1])
    );
  end

  // an all-ones stamp never beats the seed, so the seed index zero stays
  always_ff @(posedge clk) begin
    hit_r       <= hit[TLB_ENTRIES];
    hit_idx_r   <= hidx[TLB_ENTRIES];
    hit_frame_r <= hfr[TLB_ENTRIES];
    victim_r    <= free[TLB_ENTRIES] ? fidx[TLB_ENTRIES] : oidx[TLB_ENTRIES];
  end
endmodule

// File: rtl/tlb_page_table_translator.sv
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// per-process address translator: fully associative tlb over a page table
// ----------------------------------------------------------------------------
// Each item passes in order through accepting it, searching the cell chain
// and reading the page table memory, updating the cells and memory, and
// presenting the result, which is held for as long as out_stall is high. The
// next item is accepted in the cycle after the result is taken. After reset a
// clearing pass writes all PROCESSES * 2**MAX_PAGE_BITS (1024) page table
// words, during which no item is accepted.
module tlb_page_table_translator #(
  parameter int TLB_ENTRIES     = tlbpt_pkg::TLB_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tlbpt_pkg::OP_W-1:0]     in_opcode,
  input  logic [tlbpt_pkg::PID_W-1:0]    in_process_id,
  input  logic [tlbpt_pkg::VA_W-1:0]     in_virtual_address,
  input  logic [tlbpt_pkg::PN_W-1:0]     in_page_number,
  input  logic [tlbpt_pkg::FN_W-1:0]     in_frame_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tlbpt_pkg::ST_W-1:0]     out_status,
  output logic [tlbpt_pkg::VA_W-1:0]     out_physical_address,
  output logic [tlbpt_pkg::EIDX_W-1:0]   out_entry_index,
  output logic [tlbpt_pkg::FN_W-1:0]     out_frame_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [31:0]                   cfg_data
);
  import tlbpt_pkg::*;

  localparam int PROCESSES       = PROCESSES_DEF;
  localparam int MAX_PAGE_BITS   = MAX_PAGE_BITS_DEF;
  localparam int MAX_FRAME_BITS  = MAX_FRAME_BITS_DEF;
  localparam int MAX_OFFSET_BITS = MAX_OFFSET_BITS_DEF;

  localparam int IDX_W  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int PIDB   = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int PT_AW  = PIDB + MAX_PAGE_BITS;
  localparam int PT_DEPTH = PROCESSES * (2 ** MAX_PAGE_BITS);
  localparam int FW     = MAX_FRAME_BITS;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SEARCH, S_UPDATE, S_OUT} state_t;

  state_t state_r;
  logic [3:0]  offset_bits_r, vpn_bits_r;
  logic        lru_r;
  logic [STAMP_W-1:0] stamp_r;
  logic [PT_AW:0] clr_r;

  logic [OP_W-1:0]  op_r;
  logic [PID_W-1:0] pid_r;
  logic [VA_W-1:0]  va_r;
  logic [PN_W-1:0]  page_r;
  logic [FN_W-1:0]  fn_r;
  logic             range_r;
  logic [4:0]       off_r;

  logic [FW:0]     pt_mem [PT_DEPTH];
  logic [FW:0]     pt_rd_r;
  logic            pt_we;
  logic [PT_AW-1:0] pt_wa;
  logic [FW:0]     pt_wd;
  logic [PT_AW-1:0] pt_slot;

  logic [ST_W-1:0]   st_r;
  logic [VA_W-1:0]   pa_r;
  logic [EIDX_W-1:0] ei_r;
  logic [FN_W-1:0]   fo_r;

  logic hit_r;
  logic [IDX_W-1:0] hit_idx_r, victim_r;
  logic [FN_W-1:0]  hit_frame_r;
  cell_cmd_t cmd;

  logic accept;
  logic [4:0]  off_c, vb_c;
  logic [PN_W-1:0] page_c;
  logic [VA_W:0] page_full;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == S_OUT);
  assign out_status = st_r;
  assign out_physical_address = pa_r;
  assign out_entry_index = ei_r;
  assign out_frame_out = fo_r;

  assign off_c = (offset_bits_r > 4'(MAX_OFFSET_BITS)) ? 5'(MAX_OFFSET_BITS)
                                                      : {1'b0, offset_bits_r};
  assign vb_c  = (vpn_bits_r > 4'(MAX_PAGE_BITS)) ? 5'(MAX_PAGE_BITS)
                                                 : {1'b0, vpn_bits_r};
  assign page_full = (in_opcode == OP_XLATE) ? ({1'b0, in_virtual_address} >> off_c)
                                             : (VA_W+1)'(in_page_number);
  assign page_c = page_full[PN_W-1:0];
  assign pt_slot = {pid_r[PIDB-1:0], page_r[MAX_PAGE_BITS-1:0]};

  tlbpt_chain #(.TLB_ENTRIES(TLB_ENTRIES), .IDX_W(IDX_W)) u_chain (
    .clk(clk), .rst_n(rst_n), .key_page(page_r), .key_pid(pid_r), .cmd(cmd),
    .hit_r(hit_r), .hit_idx_r(hit_idx_r), .hit_frame_r(hit_frame_r),
    .victim_r(victim_r)
  );

  // update step: drive cells and page table from the search results; during clear, zero the word at clr_r
  always_comb begin
    logic [IDX_W-1:0] tgt;
    logic [FN_W-1:0]  fr;
    cmd = '0;
    pt_we = 1'b0;
    pt_wa = pt_slot;
    pt_wd = '0;
    tgt = hit_r ? hit_idx_r : victim_r;
    fr  = hit_r ? hit_frame_r : FN_W'(pt_rd_r[FW-1:0]);
    cmd.page  = page_r;
    cmd.owner = pid_r;
    cmd.stamp = stamp_r + 1'b1;
    cmd.frame = fr;
    cmd.wr_idx = 6'(tgt);
    if (state_r == S_CLEAR) begin
      pt_we = 1'b1;
      pt_wa = clr_r[PT_AW-1:0];
    end else if (state_r == S_UPDATE && !range_r) begin
      case (op_r)
        OP_XLATE: begin
          if (hit_r) cmd.touch = lru_r;
          else cmd.write = pt_rd_r[FW];
        end
        OP_MAP: begin
          pt_we = 1'b1;
          pt_wd = {1'b1, fn_r[FW-1:0]};
          cmd.frame = fn_r;
          cmd.write = 1'b1;
        end
        OP_UNMAP: begin
          pt_we = 1'b1;
          cmd.clear = hit_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[pt_wa] <= pt_wd;
    pt_rd_r <= pt_mem[pt_slot];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      offset_bits_r <= 4'd4;
      vpn_bits_r <= 4'd4;
      lru_r <= 1'b1;
      stamp_r <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_OFFSET: offset_bits_r <= cfg_data[3:0];
          CFG_VPN:    vpn_bits_r    <= cfg_data[3:0];
          CFG_LRU:    lru_r         <= cfg_data[0];
          default: ;
        endcase
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (PT_AW+1)'(PT_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            op_r <= in_opcode;
            pid_r <= in_process_id;
            va_r <= in_virtual_address;
            page_r <= page_c;
            fn_r <= in_frame_number & FN_W'((2 ** FW) - 1);
            off_r <= off_c;
            range_r <= (in_opcode != OP_NONE) &&
                       ((32'(in_process_id) >= PROCESSES) ||
                        (page_full >= ((VA_W+1)'(1) << vb_c)));
            state_r <= S_SEARCH;
          end
        end
        S_SEARCH: state_r <= S_UPDATE;
        S_UPDATE: begin
          st_r <= ST_DONE; pa_r <= '0; ei_r <= '0; fo_r <= '0;
          if (op_r == OP_NONE) begin
          end else if (range_r) begin
            st_r <= ST_RANGE;
          end else begin
            case (op_r)
              OP_XLATE: begin
                if (hit_r || pt_rd_r[FW]) begin
                  stamp_r <= stamp_r + 1'b1;
                  st_r <= hit_r ? ST_DONE : ST_FILL;
                  ei_r <= EIDX_W'(cmd.wr_idx);
                  fo_r <= cmd.frame;
                  pa_r <= VA_W'(({8'd0, cmd.frame} << off_r) |
                         (va_r & ((VA_W'(1) << off_r) - 1'b1)));
                end else begin
                  st_r <= ST_FAULT;
                end
              end
              OP_MAP: begin
                stamp_r <= stamp_r + 1'b1;
                ei_r <= EIDX_W'(cmd.wr_idx);
                fo_r <= fn_r;
              end
              default: begin
                stamp_r <= stamp_r + 1'b1;
                if (hit_r) ei_r <= EIDX_W'(hit_idx_r);
              end
            endcase
          end
          state_r <= S_OUT;
        end
        S_OUT: if (!out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> in_stall) else $error("item taken during clear");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("result dropped");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.write, cmd.clear, cmd.touch})) else $error("cell command clash");
endmodule
